// File: rtl/core/hmlf_pkg.sv
// Package with shared constants, types and character tables of the HTTP message length framer.
package hmlf_pkg;

  // Width of the internal length counters and accumulator.
  localparam int LENGTH_BITS = 24;
  // Width of the reported message length.
  localparam int OUT_BITS = 24;
  // Width that holds both the internal counter and the reported length.
  localparam int WIDE_BITS = (LENGTH_BITS > OUT_BITS) ? LENGTH_BITS : OUT_BITS;

  // Keyword and terminator geometry.
  localparam int KEY_LEN = 16;
  localparam int KEY_POS_BITS = $clog2(KEY_LEN);
  localparam int TERM_LEN = 4;
  localparam int TERM_POS_BITS = $clog2(TERM_LEN);

  // Characters with a special role.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_KEY_START = 8'h43;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // One result item.
  typedef struct packed {
    logic                message_end;
    logic [OUT_BITS-1:0] message_length;
    logic                in_body;
    logic                length_error;
  } hmlf_result_t;

  // Character of the text "Content-Length: " at a given position.
  function automatic logic [7:0] key_char(input logic [KEY_POS_BITS-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

  // Character of the CR LF CR LF header terminator at a given position.
  function automatic logic [7:0] term_char(input logic [TERM_POS_BITS-1:0] pos);
    return pos[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

// File: rtl/core/hmlf_core.sv
// Framing state and the per-item next-state and result logic.
module hmlf_core
  import hmlf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output hmlf_result_t result_o
);

  logic [KEY_POS_BITS-1:0]  key_pos_q, key_pos_d;
  logic                     reading_q, reading_d;
  logic [LENGTH_BITS-1:0]   acc_q, acc_d;
  logic [TERM_POS_BITS-1:0] term_pos_q, term_pos_d;
  logic                     body_q, body_d;
  logic [LENGTH_BITS-1:0]   count_q, count_d;
  logic [LENGTH_BITS-1:0]   remain_q, remain_d;
  logic                     error_q, error_d;

  logic                     msg_end;
  logic [LENGTH_BITS+3:0]   acc_next;
  logic [LENGTH_BITS+3:0]   digit_ext;
  logic [WIDE_BITS-1:0]     len_wide;

  // Next value of the length accumulator for a digit byte.
  always_comb begin
    digit_ext = (LENGTH_BITS + 4)'(byte_i - CHAR_ZERO) & (LENGTH_BITS + 4)'(4'hF);
    acc_next  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + digit_ext;
  end

  // Per-item update of all framing state.
  always_comb begin
    key_pos_d  = key_pos_q;
    reading_d  = reading_q;
    acc_d      = acc_q;
    term_pos_d = term_pos_q;
    body_d     = body_q;
    remain_d   = remain_q;
    error_d    = error_q;
    msg_end    = 1'b0;

    if (count_q != {LENGTH_BITS{1'b1}}) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end

    if (body_q) begin
      if (remain_q != '0) begin
        remain_d = remain_q - 1'b1;
      end
      msg_end = (remain_d == '0);
    end else begin
      // Length value or keyword search.
      if (reading_q) begin
        key_pos_d = '0;
        if (byte_i == CHAR_CR) begin
          reading_d = 1'b0;
        end else if (byte_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
          if (acc_next > {4'b0, {LENGTH_BITS{1'b1}}}) begin
            acc_d   = {LENGTH_BITS{1'b1}};
            error_d = 1'b1;
          end else begin
            acc_d = acc_next[LENGTH_BITS-1:0];
          end
        end else begin
          error_d = 1'b1;
        end
      end else begin
        if (byte_i == key_char(key_pos_q)) begin
          if (key_pos_q == KEY_POS_BITS'(KEY_LEN - 1)) begin
            reading_d = 1'b1;
            acc_d     = '0;
            key_pos_d = '0;
          end else begin
            key_pos_d = key_pos_q + 1'b1;
          end
        end else if (byte_i == CHAR_KEY_START) begin
          key_pos_d = KEY_POS_BITS'(1);
        end else begin
          key_pos_d = '0;
        end
      end

      // Header terminator search.
      if (byte_i == term_char(term_pos_q)) begin
        if (term_pos_q == TERM_POS_BITS'(TERM_LEN - 1)) begin
          term_pos_d = '0;
          body_d     = 1'b1;
          remain_d   = acc_d;
        end else begin
          term_pos_d = term_pos_q + 1'b1;
        end
      end else begin
        term_pos_d = (byte_i == CHAR_CR) ? TERM_POS_BITS'(1) : '0;
      end

      msg_end = body_d && (remain_d == '0);
    end
  end

  // Result item, with the length limited to the output width.
  always_comb begin
    len_wide = WIDE_BITS'(count_d);
    if (len_wide > WIDE_BITS'({OUT_BITS{1'b1}})) begin
      len_wide = WIDE_BITS'({OUT_BITS{1'b1}});
    end
    result_o.message_end    = msg_end;
    result_o.message_length = len_wide[OUT_BITS-1:0];
    result_o.in_body        = body_q;
    result_o.length_error   = error_d;
  end

  // State registers; a completed message clears everything.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q  <= '0;
      reading_q  <= 1'b0;
      acc_q      <= '0;
      term_pos_q <= '0;
      body_q     <= 1'b0;
      count_q    <= '0;
      remain_q   <= '0;
      error_q    <= 1'b0;
    end else if (step_i) begin
      if (msg_end) begin
        key_pos_q  <= '0;
        reading_q  <= 1'b0;
        acc_q      <= '0;
        term_pos_q <= '0;
        body_q     <= 1'b0;
        count_q    <= '0;
        remain_q   <= '0;
        error_q    <= 1'b0;
      end else begin
        key_pos_q  <= key_pos_d;
        reading_q  <= reading_d;
        acc_q      <= acc_d;
        term_pos_q <= term_pos_d;
        body_q     <= body_d;
        count_q    <= count_d;
        remain_q   <= remain_d;
        error_q    <= error_d;
      end
    end
  end

endmodule

// File: rtl/core/hmlf_out_reg.sv
// Output register that holds one result item until the downstream side takes it.
module hmlf_out_reg
  import hmlf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  hmlf_result_t result_i,
  input  logic         stall_i,
  output logic         valid_o,
  output hmlf_result_t result_o
);

  logic         valid_q;
  hmlf_result_t result_q;

  // Valid flag: set on load, cleared when the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: rtl/core/http_message_length_framer.sv
// An accepted item is held in the input register, and its result item in the result register.
// Throughput: one item per cycle; the input register and the result register each
// hold one item, and the input side stalls only while both are full and the output stalls.
// Reset (rst_ni low, asynchronous) clears the valid flags of both registers and
// the framing state, so the block starts in the header phase of a new message.
module http_message_length_framer
  import hmlf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                message_end_o,
  output logic [OUT_BITS-1:0] message_length_o,
  output logic                in_body_o,
  output logic                length_error_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         advance;
  logic         step;
  logic         out_valid;
  hmlf_result_t core_result;
  hmlf_result_t out_result;

  // The input register moves on when the result register is free or being drained.
  assign advance    = !out_valid || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Framing logic.
  hmlf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (core_result)
  );

  // Result register.
  hmlf_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (core_result),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

  assign out_valid_o      = out_valid;
  assign message_end_o    = out_result.message_end;
  assign message_length_o = out_result.message_length;
  assign in_body_o        = out_result.in_body;
  assign length_error_o   = out_result.length_error;

endmodule
